@@ rtl/core/julia_escape_time_macros.svh @@
// Assertion macros used by the escape-time engine checker.
`ifndef JULIA_ESCAPE_TIME_MACROS_SVH
`define JULIA_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define JET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define JET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define JET_ASSERT_AFTER_RST(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/jet_pkg.sv @@
// Shared types, constants and helper functions of the escape-time engine.
package jet_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int COORD_W       = 32;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int MAG_W         = 35;
  localparam int ITER_W        = 10;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [ITER_W-1:0] LIMIT_RESET = ITER_W'(64);

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_C_REAL = 2'd0;
  localparam logic [1:0] REG_C_IMAG = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef struct packed {
    logic load;    // take a new starting point
    logic mul;     // register the three products
    logic step;    // advance z and the iteration count
    logic finish;  // capture the result of this point
    logic emit;    // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic escape;    // |z|^2 of the last update exceeds the bound
    logic at_limit;  // all allowed updates have been done
  } status_t;

  // Clamp a wide signed value into the signed coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/julia_escape_time.sv @@
// Top level of the Julia set escape-time engine.
//
// The input channel (in_valid, in_ready) carries one beat per pixel: the
// starting point start_real/start_imag in signed fixed point with FRAC_BITS
// fraction bits. The output channel (out_valid, out_ready) returns one beat
// per pixel: escaped, escape_iteration and the saturated squared magnitude.
// The constant c and the iteration limit sit in registers on the APB-style
// port and should only be written while no pixel is in flight.
//
// Each iteration has a multiply phase for three parallel 32x32 products
// (x*x, y*y, x*y) and an update phase for the subtract, saturate and bound test.
// The squares of a new z double as the magnitude of the update that made it,
// so a point that stops after N updates runs N+1 rounds. One pixel is worked on at a time.
// A new pixel is taken only once the previous result has moved into the
// output register.
//
// The result is kept in an output register, so the engine is ready for the
// next pixel while the previous result still waits. If the receiver stalls,
// a finished pixel waits until the output register frees up. Reset empties
// the engine and restores c to zero and the limit to 64.
module julia_escape_time #(
  parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jet_pkg::ADDR_W-1:0]         paddr,
  input  logic [jet_pkg::DATA_W-1:0]         pwdata,
  output logic [jet_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [jet_pkg::COORD_W-1:0] start_real,
  input  logic signed [jet_pkg::COORD_W-1:0] start_imag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               escaped,
  output logic [jet_pkg::ITER_W-1:0]         escape_iteration,
  output logic [jet_pkg::MAG_W-1:0]          escape_magnitude
);
  import jet_pkg::*;

  logic signed [COORD_W-1:0] c_real;
  logic signed [COORD_W-1:0] c_imag;
  logic [ITER_W-1:0]         iteration_limit;
  cmd_t                      cmd;
  status_t                   st;

  // Configuration registers.
  jet_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .iteration_limit (iteration_limit)
  );

  // The sequencer owns both handshakes and steps the datapath.
  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds z, the iteration count, the products and the result.
  jet_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk              (clk),
    .cmd              (cmd),
    .st               (st),
    .start_real       (start_real),
    .start_imag       (start_imag),
    .c_real           (c_real),
    .c_imag           (c_imag),
    .iteration_limit  (iteration_limit),
    .escaped          (escaped),
    .escape_iteration (escape_iteration),
    .escape_magnitude (escape_magnitude)
  );

endmodule

@@ rtl/core/jet_regs.sv @@
// Configuration register file behind the APB-style port.
module jet_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [jet_pkg::ADDR_W-1:0]        paddr,
  input  logic [jet_pkg::DATA_W-1:0]        pwdata,
  output logic [jet_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  output logic signed [jet_pkg::COORD_W-1:0] c_real,
  output logic signed [jet_pkg::COORD_W-1:0] c_imag,
  output logic [jet_pkg::ITER_W-1:0]        iteration_limit
);
  import jet_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real          <= '0;
      c_imag          <= '0;
      iteration_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_C_REAL: c_real <= pwdata[COORD_W-1:0];
        REG_C_IMAG: c_imag <= pwdata[COORD_W-1:0];
        REG_LIMIT:  iteration_limit <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_C_REAL: prdata = DATA_W'(unsigned'(c_real));
      REG_C_IMAG: prdata = DATA_W'(unsigned'(c_imag));
      REG_LIMIT:  prdata = DATA_W'(iteration_limit);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/jet_ctrl.sv @@
// Sequencer of the escape-time engine: multiply and update phases per iteration.
module jet_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  jet_pkg::status_t st,
  output jet_pkg::cmd_t    cmd
);
  import jet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (st.escape || st.at_limit) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/jet_dpath.sv @@
// Datapath of the escape-time engine: squares, cross product, update and bound test.
module jet_dpath #(
  parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  jet_pkg::cmd_t                      cmd,
  output jet_pkg::status_t                   st,
  input  logic signed [jet_pkg::COORD_W-1:0] start_real,
  input  logic signed [jet_pkg::COORD_W-1:0] start_imag,
  input  logic signed [jet_pkg::COORD_W-1:0] c_real,
  input  logic signed [jet_pkg::COORD_W-1:0] c_imag,
  input  logic [jet_pkg::ITER_W-1:0]         iteration_limit,
  output logic                               escaped,
  output logic [jet_pkg::ITER_W-1:0]         escape_iteration,
  output logic [jet_pkg::MAG_W-1:0]          escape_magnitude
);
  import jet_pkg::*;

  localparam logic [PROD_W-1:0] BOUND = PROD_W'(4) << FRAC_BITS;

  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic [ITER_W-1:0]         k;
  logic signed [PROD_W-1:0]  pxx;
  logic signed [PROD_W-1:0]  pyy;
  logic signed [PROD_W-1:0]  pxy;
  logic signed [PROD_W-1:0]  sx;
  logic signed [PROD_W-1:0]  sy;
  logic signed [PROD_W-1:0]  xy2;
  logic signed [PROD_W-1:0]  cr_ext;
  logic signed [PROD_W-1:0]  ci_ext;
  logic signed [PROD_W-1:0]  nx_full;
  logic signed [PROD_W-1:0]  ny_full;
  logic [PROD_W-1:0]         mag;
  logic [MAG_W-1:0]          mag_sat;
  logic                      res_escaped;
  logic [ITER_W-1:0]         res_iter;
  logic [MAG_W-1:0]          res_mag;

  // Products are floored by the arithmetic shift.
  assign sx  = pxx >>> FRAC_BITS;
  assign sy  = pyy >>> FRAC_BITS;
  assign xy2 = pxy >>> (FRAC_BITS - 1);

  assign cr_ext  = {{(PROD_W-COORD_W){c_real[COORD_W-1]}}, c_real};
  assign ci_ext  = {{(PROD_W-COORD_W){c_imag[COORD_W-1]}}, c_imag};
  assign nx_full = sx - sy - cr_ext;
  assign ny_full = xy2 - ci_ext;

  // The squares of the current z are the magnitude terms of the previous update.
  assign mag     = $unsigned(sx) + $unsigned(sy);
  assign mag_sat = (|mag[PROD_W-1:MAG_W]) ? {MAG_W{1'b1}} : mag[MAG_W-1:0];

  assign st.escape   = (k != '0) && (mag > BOUND);
  assign st.at_limit = (k == iteration_limit);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= start_real;
      y <= start_imag;
      k <= '0;
    end
    if (cmd.mul) begin
      pxx <= x * x;
      pyy <= y * y;
      pxy <= x * y;
    end
    if (cmd.step) begin
      x <= sat_coord(nx_full);
      y <= sat_coord(ny_full);
      k <= k + 1'b1;
    end
    if (cmd.finish) begin
      res_escaped <= st.escape;
      res_iter    <= st.escape ? k - 1'b1 : '0;
      res_mag     <= st.escape ? mag_sat : '0;
    end
    if (cmd.emit) begin
      escaped          <= res_escaped;
      escape_iteration <= res_iter;
      escape_magnitude <= res_mag;
    end
  end

endmodule

@@ rtl/core/jet_checker.sv @@
// Port-level checks of the escape-time engine and their binding to the top level.
`include "julia_escape_time_macros.svh"

module jet_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       escaped,
  input logic [jet_pkg::ITER_W-1:0] escape_iteration,
  input logic [jet_pkg::MAG_W-1:0]  escape_magnitude
);

  `JET_ASSERT_AFTER_RST(a_rst_empty, clk, rst, !out_valid && in_ready, "engine not empty after reset")

  `JET_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready, "took a second beat while a pixel is in flight")

  `JET_ASSERT_NOW(a_bounded_zero, clk, rst, out_valid && !escaped, (escape_iteration == '0) && (escape_magnitude == '0), "bounded pixel reports nonzero iteration or magnitude")

  `JET_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(escaped) && $stable(escape_iteration) && $stable(escape_magnitude), "stalled result changed")

endmodule

bind julia_escape_time jet_checker u_jet_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .escaped          (escaped),
  .escape_iteration (escape_iteration),
  .escape_magnitude (escape_magnitude)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the Julia set escape-time engine.
`timescale 1ns / 100ps

module tb_top;
  import jet_pkg::*;

  // Fraction bits of the coordinates and of the squared magnitude.
  localparam int FRAC = FRAC_BITS_DEF;

  // Escape bound of |z|^2 (4.0) and the largest magnitude the result can hold.
  localparam longint ESCAPE_BOUND = longint'(4) <<< FRAC;
  localparam longint MAG_CEILING  = (longint'(1) <<< MAG_W) - 1;
  localparam longint COORD_TOP    = 64'sd2147483647;
  localparam longint COORD_BOTTOM = -64'sd2147483648;

  // A register index past the last register; writes to it must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Frequently used coordinates in signed Q4.28.
  localparam logic signed [COORD_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] Q_ONE  = 32'sh1000_0000;
  localparam logic signed [COORD_W-1:0] Q_TWO  = 32'sh2000_0000;
  localparam logic signed [COORD_W-1:0] Q_NTWO = 32'shE000_0000;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_PIXELS = 200;

  typedef struct {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } pixel_t;

  typedef struct packed {
    logic              escaped;
    logic [ITER_W-1:0] iteration;
    logic [MAG_W-1:0]  magnitude;
  } escape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] start_real = '0;
  logic signed [COORD_W-1:0] start_imag = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      escaped;
  logic [ITER_W-1:0]         escape_iteration;
  logic [MAG_W-1:0]          escape_magnitude;

  julia_escape_time i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .start_real       (start_real),
    .start_imag       (start_imag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .escaped          (escaped),
    .escape_iteration (escape_iteration),
    .escape_magnitude (escape_magnitude)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Pixels waiting to be driven, and the results still owed by the engine,
  // oldest first.
  pixel_t  pixel_q[$];
  escape_t escape_q[$];

  // Our own copy of the configuration registers, tracked from the APB bus.
  logic signed [COORD_W-1:0] c_real_shadow;
  logic signed [COORD_W-1:0] c_imag_shadow;
  logic [ITER_W-1:0]         limit_shadow;

  // Idle percentages of the two sides, changed between test phases.
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 85;

  int  mismatch_count = 0;
  int  stall_cycles = 0;
  logic in_beat = 1'b0;

  // Clamp a wide signed value into the Q4.28 coordinate range.
  function automatic longint clamp_coord(input longint v);
    if (v > COORD_TOP) begin
      return COORD_TOP;
    end else if (v < COORD_BOTTOM) begin
      return COORD_BOTTOM;
    end
    return v;
  endfunction

  // Iterate z <- z*z - c from the starting point under the current register
  // values. The arithmetic shift of a signed longint rounds toward minus
  // infinity, which is exactly the truncation the engine uses. The start
  // point itself is never tested; only the point after each update is.
  function automatic escape_t escape_predict(input logic signed [COORD_W-1:0] re,
                                             input logic signed [COORD_W-1:0] im);
    longint  x;
    longint  y;
    longint  sq_x;
    longint  sq_y;
    longint  cross2;
    longint  nx;
    longint  ny;
    longint  mag;
    int      i;
    escape_t res;
    x = re;
    y = im;
    res = '0;
    for (i = 0; i < int'(limit_shadow); i++) begin
      sq_x   = (x * x) >>> FRAC;
      sq_y   = (y * y) >>> FRAC;
      cross2 = (x * y) >>> (FRAC - 1);
      ny  = clamp_coord(cross2 - longint'(c_imag_shadow));
      nx  = clamp_coord(sq_x - sq_y - longint'(c_real_shadow));
      // The bound test uses the unclamped sum; only the report saturates.
      mag = ((nx * nx) >>> FRAC) + ((ny * ny) >>> FRAC);
      x = nx;
      y = ny;
      if (mag > ESCAPE_BOUND) begin
        res.escaped   = 1'b1;
        res.iteration = i[ITER_W-1:0];
        res.magnitude = (mag > MAG_CEILING) ? MAG_CEILING[MAG_W-1:0] : mag[MAG_W-1:0];
        break;
      end
    end
    return res;
  endfunction

  task automatic queue_pixel(input logic signed [COORD_W-1:0] re,
                             input logic signed [COORD_W-1:0] im);
    pixel_t p;
    p.re = re;
    p.im = im;
    pixel_q.push_back(p);
  endtask

  // Random starting point. Most points sit in the |re|,|im| <= 2 square where
  // the orbit can stay bounded for a while; a smaller share covers the full
  // 32-bit range so that every input bit toggles.
  task automatic queue_random_pixel();
    int unsigned pick;
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
    pick = $urandom_range(99);
    if (pick < 12) begin
      re = $urandom;
      im = $urandom;
    end else if (pick < 70) begin
      re = $urandom_range(32'h4000_0000, 0) - 32'h2000_0000;
      im = $urandom_range(32'h4000_0000, 0) - 32'h2000_0000;
    end else begin
      re = $urandom_range(32'h1800_0000, 0) - 32'h0C00_0000;
      im = $urandom_range(32'h1800_0000, 0) - 32'h0C00_0000;
    end
    queue_pixel(re, im);
  endtask

  // APB write with a setup cycle, then the access cycle, completing
  // at the rising edge where pready is seen high.
  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_c(input logic signed [COORD_W-1:0] re,
                         input logic signed [COORD_W-1:0] im);
    apb_write(REG_C_REAL, re);
    apb_write(REG_C_IMAG, im);
  endtask

  // Block until every pixel has been sent and every result has come back,
  // then let the engine settle before registers change.
  task automatic wait_engine_idle();
    do @(posedge clk); while (pixel_q.size() != 0 || in_valid || escape_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver. A new beat is offered only when the line is free or the
  // previous beat was taken at the last rising edge; otherwise valid and the
  // payload are held. The random gap lands on any cycle of the engine's work.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start_real <= pixel_q[0].re;
        start_imag <= pixel_q[0].im;
        in_valid   <= 1'b1;
        void'(pixel_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Register shadow, updated on the same edge the engine takes the write.
  always @(posedge clk) begin
    if (rst) begin
      c_real_shadow <= '0;
      c_imag_shadow <= '0;
      limit_shadow  <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_C_REAL: begin
          c_real_shadow <= pwdata;
        end
        REG_C_IMAG: begin
          c_imag_shadow <= pwdata;
        end
        REG_LIMIT: begin
          limit_shadow <= pwdata[ITER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Monitor: predict on every accepted input beat, and compare every
  // accepted output beat against the oldest outstanding prediction.
  always @(posedge clk) begin : beat_monitor
    escape_t want;
    if (rst) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (escape_q.size() == 0) begin
          $display("%0t: unexpected result beat: escaped=%0b iteration=%0d magnitude=%0d",
                   $time, escaped, escape_iteration, escape_magnitude);
          mismatch_count++;
        end else begin
          want = escape_q.pop_front();
          if (escaped !== want.escaped) begin
            $display("%0t: escaped mismatch: expected %0b, got %0b",
                     $time, want.escaped, escaped);
            mismatch_count++;
          end
          if (escape_iteration !== want.iteration) begin
            $display("%0t: escape_iteration mismatch: expected %0d, got %0d",
                     $time, want.iteration, escape_iteration);
            mismatch_count++;
          end
          if (escape_magnitude !== want.magnitude) begin
            $display("%0t: escape_magnitude mismatch: expected 0x%09h, got 0x%09h",
                     $time, want.magnitude, escape_magnitude);
            mismatch_count++;
          end
        end
      end
      // Pop before push: a result never leaves in the same cycle its pixel
      // enters, so ordering against the queue head is preserved.
      if (in_valid && in_ready) begin
        escape_q.push_back(escape_predict(start_real, start_imag));
      end
    end
  end

  // Watchdog: any accepted beat on either channel or the register port
  // counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, escape_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: c = 0 and a limit of 64. The origin stays put, 1.0 is a
    // fixed point, and the range extremes blow up at once with a magnitude
    // that still fits the 35-bit report.
    queue_pixel('0, '0);
    queue_pixel(Q_MAX, Q_MAX);
    queue_pixel(Q_MIN, Q_MIN);
    queue_pixel(Q_MIN, Q_MAX);
    queue_pixel(Q_MAX, Q_MIN);
    queue_pixel(Q_ONE, '0);
    queue_pixel(Q_TWO, '0);
    queue_pixel('0, 32'sh1800_0000);
    queue_pixel(32'sh1800_0000, 32'shE800_0000);
    wait_engine_idle();

    // With a zero limit no update happens, so nothing can escape.
    apb_write(REG_LIMIT, '0);
    queue_pixel(Q_MAX, Q_MAX);
    queue_pixel(Q_MIN, '0);
    wait_engine_idle();

    // Only the low ten bits of the limit are kept (this yields 3), and a
    // write past the last register must leave everything unchanged.
    apb_write(REG_LIMIT, 32'hFFFF_FC03);
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    queue_pixel('0, '0);
    queue_pixel(32'sh1333_3333, 32'sh04CC_CCCD);
    wait_engine_idle();

    // c = -2: the origin lands on |z|^2 = 4 exactly, which is not an escape,
    // and leaves on the next update.
    write_c(Q_NTWO, '0);
    apb_write(REG_LIMIT, 32'd5);
    queue_pixel('0, '0);
    wait_engine_idle();

    // Extreme constants saturate the first update in both directions.
    write_c(Q_MIN, Q_MAX);
    apb_write(REG_LIMIT, 32'd1023);
    queue_pixel('0, '0);
    queue_pixel(Q_MAX, Q_MIN);
    wait_engine_idle();
    write_c(Q_MAX, Q_MIN);
    queue_pixel('0, Q_ONE);
    wait_engine_idle();

    // Full-length runs at the largest limit, plus two points just outside the
    // unit circle that need a dozen or more updates to leave.
    write_c('0, '0);
    queue_pixel('0, '0);
    queue_pixel(Q_ONE, '0);
    queue_pixel(Q_ONE + 1, '0);
    queue_pixel(Q_ONE + 32'sd4096, 32'sd1);
    wait_engine_idle();

    // Random phases, each with its own constant, limit and idling pattern.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          // Classic dendrite-like set at c = -0.8 + 0.156i (stored negated).
          write_c(32'sd214748365, -32'sd41875931);
          apb_write(REG_LIMIT, 32'd64);
          send_idle_pct = 7;
          recv_idle_pct = 85;
        end
        1: begin
          write_c($urandom_range(32'h2000_0000, 0) - 32'h1000_0000,
                  $urandom_range(32'h2000_0000, 0) - 32'h1000_0000);
          apb_write(REG_LIMIT, $urandom_range(128, 16));
          send_idle_pct = 85;
          recv_idle_pct = 7;
        end
        default: begin
          // c = -0.4 + 0.6i, with a longer limit.
          write_c(32'sd107374182, -32'sd161061274);
          apb_write(REG_LIMIT, 32'd200);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < RANDOM_PIXELS; n++) begin
        queue_random_pixel();
      end
      wait_engine_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && escape_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
